// ----- rtl/deferred_action_timer_table_unit_defines.svh -----
// assertion macros for the deferred action timer table unit
`ifndef DEFERRED_ACTION_TIMER_TABLE_UNIT_DEFINES_SVH
`define DEFERRED_ACTION_TIMER_TABLE_UNIT_DEFINES_SVH

// checked at every edge, also while reset is held
`define DATT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// checked only outside reset
`define DATT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ----- rtl/datt_pkg.sv -----
// shared types and codes of the deferred action timer table
package datt_pkg;

    localparam int DATA_BYTES = 6;
    localparam int DATA_W     = 8 * DATA_BYTES;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_PIN  = 2'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_PIN  = 2'd2;
    localparam logic [1:0] ACT_FULL = 2'd3;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_PIN    = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [31:0]       start;
        logic [15:0]       delay;
        logic [DATA_W-1:0] payload;
        logic [2:0]        length;
        logic [7:0]        rpt;
        logic [15:0]       pin;
        logic [15:0]       order;
    } slot_rec_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic window;
    } pick_ctl_t;

endpackage

// ----- rtl/deferred_action_timer_table_unit.sv -----
// top level of the deferred action timer table unit
//
//  channel  | handshake        | fields
//  ---------+------------------+--------------------------------------------------
//  request  | s_valid/s_ready  | req_type now_ms delay_ms packet_data packet_len
//           |                  | repeat_count pin_number window_open
//  result   | m_valid/m_ready  | action out_packet out_len out_repeats out_pin
//
// one request at a time; a schedule walks the used bits one slot per cycle,
// from slot 0 until a free slot is found or the last slot is reached
// a tick reads every slot record from the memory, one per cycle
// reset clears the used bits and the order counter at once, no clearing pass
// the result register holds a stalled result; the next request is taken
// meanwhile and its result waits until the register frees
`include "deferred_action_timer_table_unit_defines.svh"

module deferred_action_timer_table_unit #(
    parameter int SLOTS        = 16,
    parameter int PACKET_BYTES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_now_ms,
    input  logic [15:0] s_delay_ms,
    input  logic [47:0] s_packet_data,
    input  logic [2:0]  s_packet_len,
    input  logic [7:0]  s_repeat_count,
    input  logic [15:0] s_pin_number,
    input  logic        s_window_open,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [47:0] m_out_packet,
    output logic [2:0]  m_out_len,
    output logic [7:0]  m_out_repeats,
    output logic [15:0] m_out_pin
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int DW = datt_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIRE,
        ST_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [15:0]      order_reg, order_next;
    logic             m_valid_reg, m_valid_next;

    // captured request
    logic [1:0]       req_type_reg, req_type_next;
    logic [31:0]      now_reg, now_next;
    logic [15:0]      delay_reg, delay_next;
    logic [DW-1:0]    data_reg, data_next;
    logic [2:0]       len_reg, len_next;
    logic [7:0]       rpt_reg, rpt_next;
    logic [15:0]      pin_reg, pin_next;
    logic             window_reg, window_next;

    // staged result and result register
    logic [1:0]       res_action_reg, res_action_next;
    logic [DW-1:0]    res_packet_reg, res_packet_next;
    logic [2:0]       res_len_reg, res_len_next;
    logic [7:0]       res_rpt_reg, res_rpt_next;
    logic [15:0]      res_pin_reg, res_pin_next;
    logic [1:0]       m_action_reg, m_action_next;
    logic [DW-1:0]    m_packet_reg, m_packet_next;
    logic [2:0]       m_len_reg, m_len_next;
    logic [7:0]       m_rpt_reg, m_rpt_next;
    logic [15:0]      m_pin_reg, m_pin_next;

    logic                mem_we;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    datt_pkg::slot_rec_t mem_wdata;
    datt_pkg::slot_rec_t mem_rdata;

    datt_pkg::pick_ctl_t pick_ctl;
    logic                pick_found;
    logic [IDX_W-1:0]    pick_idx;
    datt_pkg::slot_rec_t pick_rec;

    logic [3:0]       len_clamp;
    logic [DW-1:0]    data_masked;
    logic             s_xfer;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // length saturation and byte masking at capture
    always_comb begin
        len_clamp = ({1'b0, s_packet_len} > 4'(PACKET_BYTES)) ? 4'(PACKET_BYTES)
                                                             : {1'b0, s_packet_len};
        for (int b = 0; b < datt_pkg::DATA_BYTES; b++) begin
            data_masked[b*8 +: 8] = (4'(b) < len_clamp) ? s_packet_data[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        mem_wdata.kind    = (req_type_reg == datt_pkg::REQ_PIN) ? datt_pkg::KIND_PIN
                                                                : datt_pkg::KIND_PACKET;
        mem_wdata.start   = now_reg;
        mem_wdata.delay   = delay_reg;
        mem_wdata.payload = data_reg;
        mem_wdata.length  = len_reg;
        mem_wdata.rpt     = rpt_reg;
        mem_wdata.pin     = pin_reg;
        mem_wdata.order   = order_reg;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        used_next       = used_reg;
        order_next      = order_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        req_type_next   = req_type_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        data_next       = data_reg;
        len_next        = len_reg;
        rpt_next        = rpt_reg;
        pin_next        = pin_reg;
        window_next     = window_reg;
        res_action_next = res_action_reg;
        res_packet_next = res_packet_reg;
        res_len_next    = res_len_reg;
        res_rpt_next    = res_rpt_reg;
        res_pin_next    = res_pin_reg;
        m_action_next   = m_action_reg;
        m_packet_next   = m_packet_reg;
        m_len_next      = m_len_reg;
        m_rpt_next      = m_rpt_reg;
        m_pin_next      = m_pin_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        pick_ctl.clear  = 1'b0;
        pick_ctl.sample = rd_valid_reg;
        pick_ctl.window = window_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    idx_next      = '0;
                    req_type_next = s_req_type;
                    now_next      = s_now_ms;
                    delay_next    = s_delay_ms;
                    window_next   = s_window_open;
                    if (s_req_type == datt_pkg::REQ_SEND) begin
                        data_next = data_masked;
                        len_next  = len_clamp[2:0];
                        rpt_next  = s_repeat_count;
                        pin_next  = 16'd0;
                    end else begin
                        data_next = '0;
                        len_next  = 3'd0;
                        rpt_next  = 8'd0;
                        pin_next  = s_pin_number;
                    end
                    pick_ctl.clear = 1'b1;
                    case (s_req_type)
                        datt_pkg::REQ_SEND,
                        datt_pkg::REQ_PIN:  state_next = ST_FREE;
                        datt_pkg::REQ_TICK: state_next = ST_SCAN;
                        default: begin
                            res_action_next = datt_pkg::ACT_NONE;
                            res_packet_next = '0;
                            res_len_next    = 3'd0;
                            res_rpt_next    = 8'd0;
                            res_pin_next    = 16'd0;
                            state_next      = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_FREE: begin
                res_packet_next = '0;
                res_len_next    = 3'd0;
                res_rpt_next    = 8'd0;
                res_pin_next    = 16'd0;
                if (!used_reg[idx_reg]) begin
                    mem_we             = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    order_next         = order_reg + 16'd1;
                    res_action_next    = datt_pkg::ACT_NONE;
                    state_next         = ST_RESULT;
                end else if (idx_reg == LAST_IDX) begin
                    res_action_next = datt_pkg::ACT_FULL;
                    state_next      = ST_RESULT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                rd_idx_next   = idx_reg;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last record is judged at this edge
                state_next = ST_FIRE;
            end
            ST_FIRE: begin
                res_action_next = datt_pkg::ACT_NONE;
                res_packet_next = '0;
                res_len_next    = 3'd0;
                res_rpt_next    = 8'd0;
                res_pin_next    = 16'd0;
                if (pick_found) begin
                    used_next[pick_idx] = 1'b0;
                    if (pick_rec.kind == datt_pkg::KIND_PACKET) begin
                        res_action_next = datt_pkg::ACT_SEND;
                        res_packet_next = pick_rec.payload;
                        res_len_next    = pick_rec.length;
                        res_rpt_next    = pick_rec.rpt;
                    end else begin
                        res_action_next = datt_pkg::ACT_PIN;
                        res_pin_next    = pick_rec.pin;
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_action_next = res_action_reg;
                    m_packet_next = res_packet_reg;
                    m_len_next    = res_len_reg;
                    m_rpt_next    = res_rpt_reg;
                    m_pin_next    = res_pin_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            used_reg     <= '0;
            order_reg    <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            used_reg     <= used_next;
            order_reg    <= order_next;
            m_valid_reg  <= m_valid_next;
        end
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        req_type_reg   <= req_type_next;
        now_reg        <= now_next;
        delay_reg      <= delay_next;
        data_reg       <= data_next;
        len_reg        <= len_next;
        rpt_reg        <= rpt_next;
        pin_reg        <= pin_next;
        window_reg     <= window_next;
        res_action_reg <= res_action_next;
        res_packet_reg <= res_packet_next;
        res_len_reg    <= res_len_next;
        res_rpt_reg    <= res_rpt_next;
        res_pin_reg    <= res_pin_next;
        m_action_reg   <= m_action_next;
        m_packet_reg   <= m_packet_next;
        m_len_reg      <= m_len_next;
        m_rpt_reg      <= m_rpt_next;
        m_pin_reg      <= m_pin_next;
    end

    datt_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    datt_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (pick_ctl),
        .rd_idx      (rd_idx_reg),
        .rd_used     (used_reg[rd_idx_reg]),
        .rd_data     (mem_rdata),
        .now_ms      (now_reg),
        .order_count (order_reg),
        .found       (pick_found),
        .best_idx    (pick_idx),
        .best_rec    (pick_rec)
    );

    assign m_valid       = m_valid_reg;
    assign m_action      = m_action_reg;
    assign m_out_packet  = m_packet_reg;
    assign m_out_len     = m_len_reg;
    assign m_out_repeats = m_rpt_reg;
    assign m_out_pin     = m_pin_reg;

    `DATT_ASSERT(a_reset_idle, !aresetn |=> (!m_valid && s_ready), "reset did not idle the unit")
    `DATT_ASSERT_RST(a_one_request, (s_valid && s_ready) |=> !s_ready, "second request taken early")
    `DATT_ASSERT_RST(a_fire_used, (state_reg == ST_FIRE && pick_found) |-> used_reg[pick_idx], "firing a free slot")
    `DATT_ASSERT_RST(a_full_only, (state_reg == ST_FREE && idx_reg == LAST_IDX && used_reg[idx_reg]) |-> (&used_reg), "rejected while a slot is free")

endmodule

// ----- rtl/datt_slot_mem.sv -----
// slot record memory, one write port and one registered read port
module datt_slot_mem #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [IDX_W-1:0]         waddr,
    input  datt_pkg::slot_rec_t      wdata,
    input  logic                     re,
    input  logic [IDX_W-1:0]         raddr,
    output datt_pkg::slot_rec_t      rdata
);

    datt_pkg::slot_rec_t mem [SLOTS];
    datt_pkg::slot_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/datt_pick.sv -----
// running selection of the most recent due slot during a tick scan
module datt_pick #(
    parameter int IDX_W = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  datt_pkg::pick_ctl_t  ctl,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic                 rd_used,
    input  datt_pkg::slot_rec_t  rd_data,
    input  logic [31:0]          now_ms,
    input  logic [15:0]          order_count,
    output logic                 found,
    output logic [IDX_W-1:0]     best_idx,
    output datt_pkg::slot_rec_t  best_rec
);

    logic                found_reg;
    logic [15:0]         best_age_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    datt_pkg::slot_rec_t best_rec_reg;

    logic [31:0] elapsed;
    logic [15:0] age;
    logic        eligible;
    logic        take;

    always_comb begin
        elapsed  = now_ms - rd_data.start;
        age      = order_count - rd_data.order;
        eligible = ctl.sample && rd_used && (elapsed >= {16'd0, rd_data.delay})
                   && ((rd_data.kind == datt_pkg::KIND_PIN) || ctl.window);
        // strict compare keeps the lowest index on equal age
        take     = eligible && (!found_reg || (age < best_age_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
        if (take) begin
            best_age_reg <= age;
            best_idx_reg <= rd_idx;
            best_rec_reg <= rd_data;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best_rec = best_rec_reg;

endmodule

// ----- bench/tb_deferred_action_timer_table_unit.sv -----
`timescale 1ns / 100ps
// testbench for the deferred action timer table unit with a scoreboard

module tb_deferred_action_timer_table_unit;

    localparam int SLOTS      = 16;
    localparam int KEEP_BYTES = datt_pkg::DATA_BYTES;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 10;

    typedef struct packed {
        logic [1:0]                  action;
        logic [datt_pkg::DATA_W-1:0] packet;
        logic [2:0]                  len;
        logic [7:0]                  repeats;
        logic [15:0]                 pin;
    } timer_action_t;

    class action_table_checker;
        bit                  slot_busy [SLOTS];
        datt_pkg::slot_rec_t slot_rec [SLOTS];
        bit [15:0]           sched_stamp;
        timer_action_t       pending_actions [$];
        int                  errors;

        // works out the action caused by one request transfer and queues it
        function void take_request(logic [1:0] req, logic [31:0] now, logic [15:0] dly,
                                   logic [datt_pkg::DATA_W-1:0] data, logic [2:0] len,
                                   logic [7:0] rpt, logic [15:0] pin, logic win);
            timer_action_t               res;
            int                          i;
            int                          free_idx;
            int                          best;
            logic [15:0]                 age;
            logic [15:0]                 best_age;
            logic [31:0]                 elapsed;
            logic [2:0]                  keep_len;
            logic [datt_pkg::DATA_W-1:0] mask;
            res = '0;
            if (req == datt_pkg::REQ_SEND || req == datt_pkg::REQ_PIN) begin
                free_idx = -1;
                for (i = 0; i < SLOTS; i++) begin
                    if (!slot_busy[i] && free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (free_idx < 0) begin
                    res.action = datt_pkg::ACT_FULL;
                end else begin
                    slot_busy[free_idx] = 1'b1;
                    slot_rec[free_idx] = '0;
                    slot_rec[free_idx].start = now;
                    slot_rec[free_idx].delay = dly;
                    slot_rec[free_idx].order = sched_stamp;
                    sched_stamp = sched_stamp + 16'd1;
                    if (req == datt_pkg::REQ_SEND) begin
                        keep_len = (len > KEEP_BYTES) ? 3'(KEEP_BYTES) : len;
                        // a shift by the full width leaves an empty mask
                        mask = {datt_pkg::DATA_W{1'b1}} >> (8 * (KEEP_BYTES - keep_len));
                        slot_rec[free_idx].kind = datt_pkg::KIND_PACKET;
                        slot_rec[free_idx].length = keep_len;
                        slot_rec[free_idx].payload = data & mask;
                        slot_rec[free_idx].rpt = rpt;
                    end else begin
                        slot_rec[free_idx].kind = datt_pkg::KIND_PIN;
                        slot_rec[free_idx].pin = pin;
                    end
                end
            end else if (req == datt_pkg::REQ_TICK) begin
                best = -1;
                best_age = '0;
                for (i = 0; i < SLOTS; i++) begin
                    elapsed = now - slot_rec[i].start;
                    age = sched_stamp - slot_rec[i].order;
                    if (slot_busy[i] && elapsed >= {16'd0, slot_rec[i].delay}
                            && (slot_rec[i].kind == datt_pkg::KIND_PIN || win)
                            && (best < 0 || age < best_age)) begin
                        best = i;
                        best_age = age;
                    end
                end
                if (best >= 0) begin
                    if (slot_rec[best].kind == datt_pkg::KIND_PACKET) begin
                        res.action = datt_pkg::ACT_SEND;
                        res.packet = slot_rec[best].payload;
                        res.len = slot_rec[best].length;
                        res.repeats = slot_rec[best].rpt;
                    end else begin
                        res.action = datt_pkg::ACT_PIN;
                        res.pin = slot_rec[best].pin;
                    end
                    slot_busy[best] = 1'b0;
                end
            end
            pending_actions.push_back(res);
        endfunction

        function void compare_field(string name, logic [datt_pkg::DATA_W-1:0] want,
                                    logic [datt_pkg::DATA_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_action(logic [1:0] action, logic [datt_pkg::DATA_W-1:0] packet,
                                   logic [2:0] len, logic [7:0] repeats, logic [15:0] pin);
            timer_action_t want;
            if (pending_actions.size() == 0) begin
                $error("result with none outstanding: action %0d", action);
                errors++;
            end else begin
                want = pending_actions.pop_front();
                compare_field("action", datt_pkg::DATA_W'(want.action),
                              datt_pkg::DATA_W'(action));
                compare_field("out_packet", want.packet, packet);
                compare_field("out_len", datt_pkg::DATA_W'(want.len), datt_pkg::DATA_W'(len));
                compare_field("out_repeats", datt_pkg::DATA_W'(want.repeats),
                              datt_pkg::DATA_W'(repeats));
                compare_field("out_pin", datt_pkg::DATA_W'(want.pin), datt_pkg::DATA_W'(pin));
            end
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_req_type = '0;
    logic [31:0]                 s_now_ms = '0;
    logic [15:0]                 s_delay_ms = '0;
    logic [datt_pkg::DATA_W-1:0] s_packet_data = '0;
    logic [2:0]                  s_packet_len = '0;
    logic [7:0]                  s_repeat_count = '0;
    logic [15:0]                 s_pin_number = '0;
    logic                        s_window_open = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [1:0]                  m_action;
    logic [datt_pkg::DATA_W-1:0] m_out_packet;
    logic [2:0]                  m_out_len;
    logic [7:0]                  m_out_repeats;
    logic [15:0]                 m_out_pin;

    action_table_checker sb = new;
    int                  send_idle_pct = 10;
    int                  recv_idle_pct = 45;
    int                  sched_bias = 50;
    int                  stall_cycles = 0;
    logic [31:0]         clock_ms = '0;

    deferred_action_timer_table_unit #(
        .SLOTS(SLOTS),
        .PACKET_BYTES(KEEP_BYTES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_now_ms(s_now_ms),
        .s_delay_ms(s_delay_ms),
        .s_packet_data(s_packet_data),
        .s_packet_len(s_packet_len),
        .s_repeat_count(s_repeat_count),
        .s_pin_number(s_pin_number),
        .s_window_open(s_window_open),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_action(m_action),
        .m_out_packet(m_out_packet),
        .m_out_len(m_out_len),
        .m_out_repeats(m_out_repeats),
        .m_out_pin(m_out_pin)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // results are checked before the same edge's request is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_action(m_action, m_out_packet, m_out_len, m_out_repeats, m_out_pin);
            end
            if (s_valid && s_ready) begin
                sb.take_request(s_req_type, s_now_ms, s_delay_ms, s_packet_data,
                                s_packet_len, s_repeat_count, s_pin_number, s_window_open);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] req, logic [31:0] now, logic [15:0] dly,
                                logic [datt_pkg::DATA_W-1:0] data, logic [2:0] len,
                                logic [7:0] rpt, logic [15:0] pin, logic win);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_now_ms <= now;
        s_delay_ms <= dly;
        s_packet_data <= data;
        s_packet_len <= len;
        s_repeat_count <= rpt;
        s_pin_number <= pin;
        s_window_open <= win;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // mostly a running clock with short delays so entries come due; some noise
    task automatic random_request();
        int          r;
        logic [1:0]  req;
        logic [31:0] now;
        logic [15:0] dly;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 3);
        wide = {$urandom, $urandom};
        if (r < 8) begin
            req = 2'($urandom_range(0, 3));
            now = $urandom;
            dly = 16'($urandom);
        end else begin
            req = ($urandom_range(0, 99) < sched_bias) ? 2'($urandom_range(1, 2))
                                                       : datt_pkg::REQ_TICK;
            now = clock_ms;
            dly = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        end
        send_request(req, now, dly, wide[datt_pkg::DATA_W-1:0], 3'($urandom_range(0, 7)),
                     8'($urandom), 16'($urandom), $urandom_range(0, 99) < 60);
    endtask

    initial begin
        int          k;
        int          p;
        int          n;
        logic [63:0] wide;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, then fill it with extremes and a wrapping start time
        send_request(datt_pkg::REQ_TICK, 32'd0, '0, '0, '0, '0, '0, 1'b1);
        send_request(datt_pkg::REQ_SEND, 32'd1000, 16'd0, {datt_pkg::DATA_W{1'b1}}, 3'd7,
                     8'hFF, '0, 1'b0);
        send_request(datt_pkg::REQ_SEND, 32'd1000, 16'hFFFF, {datt_pkg::DATA_W{1'b1}}, 3'd0,
                     8'h00, '0, 1'b0);
        send_request(datt_pkg::REQ_SEND, 32'd1001, 16'd5, 48'hA5A5_5A5A_C3C3, 3'd6, 8'd1,
                     '0, 1'b0);
        send_request(datt_pkg::REQ_PIN, 32'd1002, 16'd0, '0, '0, '0, 16'hFFFF, 1'b0);
        send_request(datt_pkg::REQ_PIN, 32'd1002, 16'hFFFF, '0, '0, '0, 16'h0000, 1'b0);
        for (k = 0; k < 11; k++) begin
            wide = {$urandom, $urandom};
            send_request((k % 2) ? datt_pkg::REQ_PIN : datt_pkg::REQ_SEND, 32'hFFFF_FFF0,
                         16'h0020, wide[datt_pkg::DATA_W-1:0], 3'(k), 8'($urandom),
                         16'($urandom), 1'b0);
        end
        // table is full now
        send_request(datt_pkg::REQ_PIN, 32'd1003, 16'd0, '0, '0, '0, 16'h1234, 1'b1);
        send_request(2'd3, 32'hFFFF_FFFF, 16'hFFFF, {datt_pkg::DATA_W{1'b1}}, 3'd7, 8'hFF,
                     16'hFFFF, 1'b1);
        send_request(datt_pkg::REQ_TICK, 32'd1010, '0, '0, '0, '0, '0, 1'b0);
        send_request(datt_pkg::REQ_TICK, 32'd1010, '0, '0, '0, '0, '0, 1'b1);
        send_request(datt_pkg::REQ_TICK, 32'h0000_0010, '0, '0, '0, '0, '0, 1'b0);
        send_request(datt_pkg::REQ_TICK, 32'h0000_0010, '0, '0, '0, '0, '0, 1'b1);
        send_request(datt_pkg::REQ_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, 1'b1);
        send_request(datt_pkg::REQ_TICK, 32'h0001_0400, '0, '0, '0, '0, '0, 1'b1);

        for (p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 10 : (p == 1) ? 45 : 0;
            recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 10 : 0;
            clock_ms = (p == 1) ? 32'hFFFF_FF00 : $urandom;
            for (n = 0; n < 150; n++) begin
                sched_bias = ((n / 25) % 2) ? 35 : 65;
                random_request();
            end
        end
        s_valid <= 1'b0;

        while (sb.pending_actions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
